[sv/point_cloud_inertia_tensor_defines.svh]
// Assertion macros for the point cloud inertia tensor block.
// Used by the port checker; no other dependencies.
`ifndef POINT_CLOUD_INERTIA_TENSOR_DEFINES_SVH
`define POINT_CLOUD_INERTIA_TENSOR_DEFINES_SVH
// Assert that an implication holds at every clock unless in reset.
`define PCIT_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Assert a property that is checked during reset as well.
`define PCIT_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`endif

[sv/pcit_pkg.sv]
// Shared types and constants of the point cloud inertia tensor block.
// No dependencies.
package pcit_pkg;
  localparam int MaxPoints = 1024;
  localparam int CoordBits = 16;
  localparam int AddrBits  = $clog2(MaxPoints);
  localparam int CntBits   = $clog2(MaxPoints + 1);
  localparam int SumBits   = CoordBits + AddrBits + 1;
  localparam int QDepth    = 4;
  localparam int QPtrBits  = 2;
  localparam logic [1:0] Dim2D = 2'd2;
  localparam logic [0:0] RegDimensions = 1'b0;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               last;
  } point_t;

  typedef struct packed {
    logic [10:0]        point_count;
    logic signed [23:0] center_x;
    logic signed [23:0] center_y;
    logic signed [23:0] center_z;
    logic [58:0]        moment_xx;
    logic [58:0]        moment_yy;
    logic [58:0]        moment_zz;
    logic signed [59:0] moment_xy;
    logic signed [59:0] moment_xz;
    logic signed [59:0] moment_yz;
    logic               overflow;
  } result_t;

  typedef enum logic [2:0] {
    StLoad, StDiv, StPass, StDrain, StEmit
  } back_state_e;
endpackage

[sv/pcit_if.sv]
// Valid/ready channel interfaces for points and results.
// Depends on pcit_pkg.
interface pcit_point_if;
  logic valid;
  logic ready;
  pcit_pkg::point_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pcit_result_if;
  logic valid;
  logic ready;
  pcit_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/pcit_front.sv]
// Front end: accepts points into a short queue.
// Depends on pcit_pkg.
module pcit_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pcit_pkg::point_t  in_data_i,
  output logic              q_valid_o,
  input  logic              q_pop_i,
  output pcit_pkg::point_t  q_data_o
);
  import pcit_pkg::*;
  point_t mem_q [QDepth];
  logic [QPtrBits-1:0] wp_q, rp_q;
  logic [QPtrBits:0] cnt_q;
  logic push, pop;

  assign in_ready_o = (cnt_q != QPtrBits'(0) + (QPtrBits+1)'(QDepth));
  assign push = in_valid_i && in_ready_o;
  assign q_valid_o = (cnt_q != '0);
  assign pop = q_pop_i && q_valid_o;
  assign q_data_o = mem_q[rp_q];

  // Store the entry.
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_data_i;
  end

  // Advance the pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + 1'b1;
      if (pop) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (QPtrBits+1)'(push) - (QPtrBits+1)'(pop);
    end
  end
endmodule

[sv/pcit_back.sv]
// Back end: stores points, divides, runs the second pass, emits the result.
// Depends on pcit_pkg.
module pcit_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        dims_i,
  input  logic              q_valid_i,
  output logic              q_pop_o,
  input  pcit_pkg::point_t  q_data_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output pcit_pkg::result_t res_data_o
);
  import pcit_pkg::*;
  localparam int DivBits = SumBits + 8;

  back_state_e state_q, state_d;
  logic [47:0] store_q [MaxPoints];
  logic [CntBits-1:0] cnt_q;
  logic signed [SumBits-1:0] sum_q [3];
  logic ovf_q;
  logic [1:0] axis_q;
  logic [5:0] dstep_q;
  logic [DivBits-1:0] num_q;
  logic [CntBits:0] rem_q;
  logic neg_q;
  logic signed [23:0] cen_q [3];
  logic [CntBits-1:0] idx_q;
  logic rd_v_q, mul_v_q;
  logic [47:0] rd_q;
  logic [63:0] prod_q [6];
  logic [63:0] acc_q [6];
  logic two_d;
  logic signed [CoordBits+9:0] dif [3];
  logic signed [2*(CoordBits+10)-1:0] pr [6];
  logic [CntBits:0] trial;
  logic signed [DivBits:0] snum;

  assign two_d = (dims_i == Dim2D);
  assign q_pop_o = (state_q == StLoad) && q_valid_i;
  assign trial = {rem_q[CntBits-1:0], num_q[DivBits-1]};

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StLoad:  if (q_pop_o && q_data_i.last) state_d = StDiv;
      StDiv:   if (axis_q == 2'd2 && dstep_q == 6'(DivBits) + 6'd1) state_d = StPass;
      StPass:  if (idx_q == cnt_q) state_d = StDrain;
      StDrain: if (!rd_v_q && !mul_v_q) state_d = StEmit;
      StEmit:  if (res_ready_i) state_d = StLoad;
      default: state_d = StLoad;
    endcase
  end

  // Drive the result.
  always_comb begin
    res_valid_o = (state_q == StEmit);
    res_data_o.point_count = 11'(cnt_q);
    res_data_o.center_x = cen_q[0];
    res_data_o.center_y = cen_q[1];
    res_data_o.center_z = two_d ? 24'sd0 : cen_q[2];
    res_data_o.moment_xx = acc_q[0][58:0];
    res_data_o.moment_yy = acc_q[1][58:0];
    res_data_o.moment_zz = acc_q[2][58:0];
    res_data_o.moment_xy = acc_q[3][59:0];
    res_data_o.moment_xz = acc_q[4][59:0];
    res_data_o.moment_yz = acc_q[5][59:0];
    res_data_o.overflow = ovf_q;
  end

  // Point memory write and registered read.
  always_ff @(posedge clk_i) begin
    if (q_pop_o && cnt_q != CntBits'(MaxPoints))
      store_q[cnt_q[AddrBits-1:0]] <= {q_data_i.x, q_data_i.y, q_data_i.z};
    rd_q <= store_q[idx_q[AddrBits-1:0]];
  end

  // Centered differences.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dif[k] = {{2{rd_q[47-16*k]}}, rd_q[47-16*k -: 16], 8'd0}
             - (CoordBits+10)'(cen_q[k]);
    end
    if (two_d) dif[2] = '0;
  end

  // Full-width signed products of the differences.
  always_comb begin
    pr[0] = dif[0] * dif[0];
    pr[1] = dif[1] * dif[1];
    pr[2] = dif[2] * dif[2];
    pr[3] = dif[0] * dif[1];
    pr[4] = dif[0] * dif[2];
    pr[5] = dif[1] * dif[2];
  end

  assign snum = neg_q ? -$signed({1'b0, num_q}) : $signed({1'b0, num_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad; cnt_q <= '0; ovf_q <= 1'b0;
      for (int k = 0; k < 3; k++) begin sum_q[k] <= '0; cen_q[k] <= '0; end
      for (int k = 0; k < 6; k++) begin acc_q[k] <= '0; prod_q[k] <= '0; end
      axis_q <= '0; dstep_q <= '0; num_q <= '0; rem_q <= '0; neg_q <= 1'b0;
      idx_q <= '0; rd_v_q <= 1'b0; mul_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        StLoad: if (q_pop_o) begin
          if (cnt_q != CntBits'(MaxPoints)) begin
            cnt_q <= cnt_q + 1'b1;
            sum_q[0] <= sum_q[0] + SumBits'(q_data_i.x);
            sum_q[1] <= sum_q[1] + SumBits'(q_data_i.y);
            sum_q[2] <= sum_q[2] + SumBits'(q_data_i.z);
          end else ovf_q <= 1'b1;
          axis_q <= '0; dstep_q <= '0;
        end
        StDiv: begin
          // Restoring division of |sum|*256 by count, one bit a cycle.
          if (dstep_q == '0) begin
            neg_q <= sum_q[axis_q][SumBits-1];
            num_q <= sum_q[axis_q][SumBits-1]
                   ? DivBits'(-{sum_q[axis_q], 8'd0}) : DivBits'({sum_q[axis_q], 8'd0});
            rem_q <= '0;
            dstep_q <= 6'd1;
          end else if (dstep_q <= 6'(DivBits)) begin
            if (trial >= {1'b0, cnt_q}) begin
              rem_q <= trial - {1'b0, cnt_q};
              num_q <= {num_q[DivBits-2:0], 1'b1};
            end else begin
              rem_q <= trial;
              num_q <= {num_q[DivBits-2:0], 1'b0};
            end
            dstep_q <= dstep_q + 1'b1;
          end
          // Quotient complete: apply the sign and move to the next axis.
          if (dstep_q == 6'(DivBits) + 6'd1) begin
            cen_q[axis_q] <= 24'(snum);
            axis_q <= axis_q + 1'b1;
            dstep_q <= '0;
          end
          idx_q <= '0;
          for (int k = 0; k < 6; k++) acc_q[k] <= '0;
        end
        StPass: begin
          rd_v_q <= (idx_q != cnt_q);
          if (idx_q != cnt_q) idx_q <= idx_q + 1'b1;
        end
        StDrain: rd_v_q <= 1'b0;
        StEmit: if (res_ready_i) begin
          cnt_q <= '0; ovf_q <= 1'b0;
          for (int k = 0; k < 3; k++) sum_q[k] <= '0;
        end
        default: ;
      endcase
      // Product stage, then accumulate.
      mul_v_q <= rd_v_q;
      if (rd_v_q)
        for (int k = 0; k < 6; k++) prod_q[k] <= 64'(pr[k]);
      if (mul_v_q)
        for (int k = 0; k < 6; k++) acc_q[k] <= acc_q[k] + prod_q[k];
    end
  end
endmodule

[sv/point_cloud_inertia_tensor.sv]
// Point cloud inertia tensor: centre of mass and second moments of a point set.
// Channels: in_if takes one point per request (x, y, z, last); out_if
// delivers one result per set after the request marked last arrives.
// Configuration: APB write to address 0 sets dimensions (2 = planar, else 3D).
// Points are taken into a four-entry queue at up to one per cycle and written
// to a 1024-entry point memory at one per cycle while the back end is loading.
// After the last point, the centre is found axis by axis (one quotient bit per
// cycle in a shared divider), then the second pass reads one stored point a
// cycle, and the result is valid once the products have drained.
// Points beyond 1024 are dropped and the overflow bit is set in the result.
// Reset clears counts, sums and state; the point memory is not cleared.
// While the result waits on a stalled receiver, the queue keeps filling and
// then holds in_ready low until the result is taken.
module point_cloud_inertia_tensor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:2]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  pcit_point_if.sink    in_if,
  pcit_result_if.source out_if
);
  import pcit_pkg::*;
  logic [1:0] dims_q;
  logic q_valid, q_pop;
  point_t q_data;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegDimensions) ? {30'd0, dims_q} : 32'd0;

  // Write the dimensions register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dims_q <= 2'd3;
    else if (psel && penable && pwrite && paddr[2] == RegDimensions) dims_q <= pwdata[1:0];
  end

  pcit_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready), .in_data_i(in_if.data),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_data_o(q_data)
  );

  pcit_back u_back (
    .clk_i, .rst_ni, .dims_i(dims_q),
    .q_valid_i(q_valid), .q_pop_o(q_pop), .q_data_i(q_data),
    .res_valid_o(out_if.valid), .res_ready_i(out_if.ready), .res_data_o(out_if.data)
  );
endmodule

[sv/pcit_checker.sv]
// Port checker for the point cloud inertia tensor block, with its bind.
// Depends on the assertion macros header.
`include "point_cloud_inertia_tensor_defines.svh"
module pcit_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid,
  input logic out_ready,
  input logic [10:0] out_count,
  input logic pready
);
  `PCIT_ASSERT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready |=> out_valid)
  `PCIT_ASSERT(a_cnt_hold, clk_i, rst_ni, out_valid && !out_ready |=> $stable(out_count))
  `PCIT_ASSERT(a_cnt_nz, clk_i, rst_ni, out_valid |-> out_count != 11'd0)
  `PCIT_ASSERT_ALWAYS(a_pready, clk_i, pready)
endmodule

bind point_cloud_inertia_tensor pcit_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .out_valid(out_if.valid), .out_ready(out_if.ready),
  .out_count(out_if.data.point_count), .pready(pready)
);

[verif/tb_point_cloud_inertia_tensor.sv]
// Testbench of point_cloud_inertia_tensor: streams point sets, checks each result
// against an in-bench inertia tensor calculation or a fixed directed value. Depends on pcit_pkg and pcit_if.
module tb_point_cloud_inertia_tensor;
  import pcit_pkg::*;

  typedef struct {
    logic signed [15:0] x, y, z;
    logic               last;
    logic               fixed;
    logic signed [23:0] cx, cy, cz;
  } stim_row_t;

  logic        clk_i, rst_ni;
  logic        psel, penable, pwrite;
  logic [2:2]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        calm;
  logic        failed;

  pcit_point_if  in_if ();
  pcit_result_if out_if ();

  point_cloud_inertia_tensor i_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_if(in_if.sink), .out_if(out_if.source)
  );

  // Running copy of the block's set and mode
  point_t       set_points[$];
  longint       sum_x, sum_y, sum_z;
  logic         set_dropped;
  logic [1:0]   dim_mode;
  result_t      expected_tensors[$];

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("FAILED: results differ");
    $finish;
  end

  // Close the set: centre in Q8, then six centred Q16 moments
  function automatic result_t inertia_of_set();
    result_t r;
    longint  cnt, cx, cy, cz, dx, dy, dz;
    logic [63:0] mxx, myy, mzz, mxy, mxz, myz;
    cnt = set_points.size();
    cx = (sum_x * 256) / cnt;
    cy = (sum_y * 256) / cnt;
    cz = (dim_mode == Dim2D) ? 0 : (sum_z * 256) / cnt;
    {mxx, myy, mzz, mxy, mxz, myz} = '0;
    foreach (set_points[i]) begin
      dx = longint'(set_points[i].x) * 256 - cx;
      dy = longint'(set_points[i].y) * 256 - cy;
      dz = (dim_mode == Dim2D) ? 0 : longint'(set_points[i].z) * 256 - cz;
      mxx += dx * dx; myy += dy * dy; mzz += dz * dz;
      mxy += dx * dy; mxz += dx * dz; myz += dy * dz;
    end
    r.point_count = cnt[10:0];
    r.center_x = cx[23:0]; r.center_y = cy[23:0]; r.center_z = cz[23:0];
    r.moment_xx = mxx[58:0]; r.moment_yy = myy[58:0]; r.moment_zz = mzz[58:0];
    r.moment_xy = mxy[59:0]; r.moment_xz = mxz[59:0]; r.moment_yz = myz[59:0];
    r.overflow = set_dropped;
    return r;
  endfunction

  // Take one accepted point into the set; on the last point, output the set's result
  function automatic void absorb_point(point_t p, output result_t r);
    if (set_points.size() < MaxPoints) begin
      set_points.push_back(p);
      sum_x += p.x; sum_y += p.y; sum_z += p.z;
    end else begin
      set_dropped = 1'b1;
    end
    if (p.last) begin
      r = inertia_of_set();
      set_points.delete();
      sum_x = 0; sum_y = 0; sum_z = 0;
      set_dropped = 1'b0;
    end
  endfunction

  // Send one point request, with random gaps ahead of it unless calm
  task automatic send_point(point_t p, logic fixed = 0, result_t fixed_r = '0);
    result_t r;
    while (!calm && $urandom_range(99) < 23) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= p;
    do @(posedge clk_i); while (!in_if.ready);
    absorb_point(p, r);
    if (p.last) expected_tensors.push_back(fixed ? fixed_r : r);
  endtask

  task automatic write_dims(logic [1:0] v);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= '0; pwdata <= 32'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    dim_mode = v;
  endtask

  task automatic wait_idle();
    while (expected_tensors.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Drive random readiness on the result side (always ready when calm) and check each result
  always @(posedge clk_i) begin
    out_if.ready <= calm ? 1'b1 : ($urandom_range(99) >= 23);
    if (!rst_ni) begin
      failed <= 1'b0;
    end else if (out_if.valid && out_if.ready) begin
      if (expected_tensors.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_if.data);
        failed <= 1'b1;
      end else begin
        if (out_if.data !== expected_tensors[0]) begin
          $display("%0t: expected %p", $time, expected_tensors[0]);
          $display("%0t: actual   %p", $time, out_if.data);
          failed <= 1'b1;
        end
        expected_tensors.pop_front();
      end
    end
  end

  stim_row_t directed_rows[] = '{
    '{16'sh7fff, -16'sh8000, 16'sh0000, 1, 1, 24'sh7fff00, -24'sh800000, 24'sh0},
    '{-16'sh8000, 16'sh7fff, -16'sh0001, 1, 1, -24'sh800000, 24'sh7fff00, -24'sh100},
    '{16'sh0000, 16'sh0000, 16'sh0000, 0, 0, 0, 0, 0},
    '{16'sh7fff, -16'sh8000, 16'sh7fff, 1, 0, 0, 0, 0},
    '{16'sh0003, 16'sh0005, -16'sh0007, 0, 0, 0, 0, 0},
    '{-16'sh0002, 16'sh0001, 16'sh0004, 0, 0, 0, 0, 0},
    '{16'sh0001, -16'sh0001, 16'sh0000, 1, 0, 0, 0, 0},
    '{16'sh5555, 16'shaaa, -16'sh5556, 0, 0, 0, 0, 0},
    '{-16'sh8000, -16'sh8000, -16'sh8000, 0, 0, 0, 0, 0},
    '{16'sh7fff, 16'sh7fff, 16'sh7fff, 1, 0, 0, 0, 0}
  };

  initial begin
    logic [1:0] phase_dims[6] = '{Dim2D, 2'd0, 2'd1, 2'd3, Dim2D, 2'd3};
    point_t  p;
    result_t fr;
    int      n, guard;
    calm = 0; rst_ni = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_if.valid = 0; in_if.data = '0;
    sum_x = 0; sum_y = 0; sum_z = 0; set_dropped = 0; dim_mode = 2'd3;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows: extremes and small sets in the reset mode
    foreach (directed_rows[i]) begin
      p = '{directed_rows[i].x, directed_rows[i].y, directed_rows[i].z,
            directed_rows[i].last};
      fr = '0;
      fr.point_count = 11'd1;
      fr.center_x = directed_rows[i].cx;
      fr.center_y = directed_rows[i].cy;
      fr.center_z = directed_rows[i].cz;
      send_point(p, directed_rows[i].fixed, fr);
    end

    // Random phases over all modes; one phase fills past capacity
    foreach (phase_dims[ph]) begin
      in_if.valid <= 1'b0;
      wait_idle();
      calm = (ph == 3);
      write_dims(phase_dims[ph]);
      if (ph == 2) begin
        for (int i = 0; i < MaxPoints + 6; i++)
          send_point('{rand_coord(), rand_coord(), rand_coord(), i == MaxPoints + 5});
      end
      for (int s = 0; s < 5; s++) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
          send_point('{rand_coord(), rand_coord(), rand_coord(), i == n - 1});
      end
    end
    in_if.valid <= 1'b0;
    calm = 0;

    // Drain, then let the block settle
    guard = 0;
    while (expected_tensors.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (1200) @(posedge clk_i);
    if (!failed && expected_tensors.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
